// ----- rtl/circular_byte_buffer_top_defines.svh -----
// ----------------------------------------------------------------------------
// circular_byte_buffer_top_defines.svh
// Assertion macros for the circular byte buffer.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_BYTE_BUFFER_TOP_DEFINES_SVH
`define CIRCULAR_BYTE_BUFFER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define CBB_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

`define CBB_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define CBB_ASSERT_IMP(lbl, ante, cons)

`define CBB_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ----- rtl/cbb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbb_pkg
// Types and constants shared by the circular byte buffer.
// ----------------------------------------------------------------------------
package cbb_pkg;

	localparam int unsigned DEPTH  = 4096;
	localparam int unsigned ADDR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W  = ADDR_W + 1;
	localparam int unsigned DATA_W = 8;
	localparam int unsigned OP_W   = 3;
	localparam int unsigned CMD_QD = 2;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR   = 3'd0,
		OP_COMMIT  = 3'd1,
		OP_CONSUME = 3'd2,
		OP_SET     = 3'd3,
		OP_GET     = 3'd4,
		OP_RD_SEG  = 3'd5,
		OP_WR_SEG  = 3'd6,
		OP_FILL    = 3'd7
	} cbb_op_t;

	typedef struct packed {
		cbb_op_t           op;
		logic [CNT_W-1:0]  amount;
		logic [ADDR_W-1:0] offset;
		logic [DATA_W-1:0] data;
	} cbb_cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0]  cap;
		logic [CNT_W-1:0]  fill;
		logic [ADDR_W-1:0] head;
		logic [ADDR_W-1:0] tail;
	} cbb_stat_t;

endpackage

// ----- rtl/cbb_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbb_in_if
// Request channel: one operation per item.
// ----------------------------------------------------------------------------
interface cbb_in_if import cbb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [CNT_W-1:0]  amount;
	logic [ADDR_W-1:0] offset;
	logic [DATA_W-1:0] data_in;

	modport source (output valid, op, amount, offset, data_in, input ready);
	modport sink   (input valid, op, amount, offset, data_in, output ready);
endinterface

// ----- rtl/cbb_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbb_out_if
// Response channel: status, read byte and segment descriptors.
// ----------------------------------------------------------------------------
interface cbb_out_if import cbb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              status;
	logic [DATA_W-1:0] read_byte;
	logic [ADDR_W-1:0] seg_start;
	logic [CNT_W-1:0]  seg_length;
	logic              last;
	logic [CNT_W-1:0]  readable_count;

	modport source (output valid, status, read_byte, seg_start, seg_length, last,
		readable_count, input ready);
	modport sink   (input valid, status, read_byte, seg_start, seg_length, last,
		readable_count, output ready);
endinterface

// ----- rtl/cbb_cfg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbb_cfg_if
// Capacity register write channel.
// ----------------------------------------------------------------------------
interface cbb_cfg_if import cbb_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/circular_byte_buffer_top.sv -----
`timescale 1ns / 1ps
// Path: an accepted request is queued in cbb_front, then registered into the response register.
// Throughput: 1 request per cycle while response items are accepted; a wrapped
// segment list holds the single response register until both of its items are taken.
// Reset: indices and fill count cleared, capacity 4096; byte store contents
// undefined until written, no clearing pass.
// ----------------------------------------------------------------------------
// circular_byte_buffer_top
// Ring byte store with decoupled request decode and execution.
// ----------------------------------------------------------------------------
`include "circular_byte_buffer_top_defines.svh"

module circular_byte_buffer_top import cbb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	cbb_in_if.sink    req,
	cbb_out_if.source rsp,
	cbb_cfg_if.sink   cfg
);

	logic      cmd_valid;
	cbb_cmd_t  cmd;
	logic      cmd_pop;
	cbb_stat_t stat;

	cbb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	cbb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.cfg       (cfg),
		.rsp       (rsp),
		.stat      (stat)
	);

	`CBB_ASSERT_IMP(a_fill_le_cap, 1'b1, stat.fill <= stat.cap)
	`CBB_ASSERT_IMP(a_pos_in_ring, 1'b1, ({1'b0, stat.head} < stat.cap) && ({1'b0, stat.tail} < stat.cap))
	`CBB_ASSERT_IMP(a_err_shape, rsp.valid && rsp.status, rsp.last && (rsp.seg_length == '0))
	`CBB_ASSERT_NXT(a_cfg_empties, cfg.valid && cfg.ready, stat.fill == '0)

endmodule

// ----- rtl/cbb_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbb_front
// Accepts request items, decodes the operation and queues them (2 deep).
// ----------------------------------------------------------------------------
module cbb_front import cbb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	cbb_in_if.sink   req,
	output logic     cmd_valid,
	output cbb_cmd_t cmd,
	input  logic     cmd_pop
);

	cbb_cmd_t         q_q [CMD_QD];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             push;
	cbb_cmd_t         cmd_in;

	assign req.ready = (cnt_q != 2'(CMD_QD));
	assign push      = req.valid && req.ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_q[rd_ptr_q];

	always_comb begin
		cmd_in.op     = cbb_op_t'(req.op);
		cmd_in.amount = req.amount;
		cmd_in.offset = req.offset;
		cmd_in.data   = req.data_in;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, cmd_pop})
				2'b10: begin
					cnt_q <= cnt_q + 2'd1;
				end
				2'b01: begin
					cnt_q <= cnt_q - 2'd1;
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

endmodule

// ----- rtl/cbb_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbb_back
// Executes queued operations: bounds checks, index updates, byte store
// access and the response register.
// ----------------------------------------------------------------------------
module cbb_back import cbb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	input  cbb_cmd_t  cmd,
	output logic      cmd_pop,
	cbb_cfg_if.sink   cfg,
	cbb_out_if.source rsp,
	output cbb_stat_t stat
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_q;

	logic [CNT_W-1:0]  cap_q;
	logic [CNT_W-1:0]  fill_q;
	logic [ADDR_W-1:0] head_q;
	logic [ADDR_W-1:0] tail_q;

	logic              res_valid_s1;
	logic              res_status_s1;
	logic              res_get_s1;
	logic [ADDR_W-1:0] res_start_s1;
	logic [CNT_W-1:0]  res_len_s1;
	logic              res_last_s1;
	logic [CNT_W-1:0]  res_cnt_s1;
	logic              res_has2_s1;
	logic [CNT_W-1:0]  res_len2_s1;

	logic              cfg_we;
	logic              rsp_acc;
	logic [CNT_W-1:0]  cfg_cap;
	logic [CNT_W-1:0]  free_sp;
	logic              use_tail;
	logic              use_off;
	logic [ADDR_W-1:0] base;
	logic [CNT_W-1:0]  addend;
	logic [CNT_W:0]    sum;
	logic [CNT_W:0]    wrapped;
	logic [ADDR_W-1:0] pos_new;
	logic [CNT_W-1:0]  seg_first;
	logic              seg_one;
	logic [CNT_W-1:0]  seg_rest;

	logic              err;
	logic              wr_en;
	logic              rd_en;
	logic [ADDR_W-1:0] nxt_head;
	logic [ADDR_W-1:0] nxt_tail;
	logic [CNT_W-1:0]  nxt_fill;
	logic [ADDR_W-1:0] r_start;
	logic [CNT_W-1:0]  r_len;
	logic              r_has2;
	logic [CNT_W-1:0]  r_len2;

	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid && cfg.ready;
	assign rsp_acc   = rsp.valid && rsp.ready;
	assign cmd_pop   = cmd_valid && (!res_valid_s1 || (rsp_acc && !res_has2_s1));

	always_comb begin
		if (cfg.data == '0) begin
			cfg_cap = CNT_W'(1);
		end else if (cfg.data > CNT_W'(DEPTH)) begin
			cfg_cap = CNT_W'(DEPTH);
		end else begin
			cfg_cap = cfg.data;
		end
	end

	assign free_sp  = cap_q - fill_q;
	assign use_tail = (cmd.op == OP_COMMIT) || (cmd.op == OP_WR_SEG) || (cmd.op == OP_FILL);
	assign use_off  = (cmd.op == OP_SET) || (cmd.op == OP_GET) || (cmd.op == OP_FILL);
	assign base     = use_tail ? tail_q : head_q;
	assign addend   = use_off ? {1'b0, cmd.offset} : cmd.amount;
	assign sum      = {2'b00, base} + {1'b0, addend};
	assign wrapped  = (sum >= {1'b0, cap_q}) ? (sum - {1'b0, cap_q}) : sum;
	assign pos_new  = wrapped[ADDR_W-1:0];

	assign seg_first = cap_q - {1'b0, base};
	assign seg_one   = (seg_first >= cmd.amount);
	assign seg_rest  = cmd.amount - seg_first;

	always_comb begin
		err      = 1'b0;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		nxt_head = head_q;
		nxt_tail = tail_q;
		nxt_fill = fill_q;
		r_start  = '0;
		r_len    = '0;
		r_has2   = 1'b0;
		r_len2   = '0;
		unique case (cmd.op)
			OP_CLEAR: begin
				nxt_head = '0;
				nxt_tail = '0;
				nxt_fill = '0;
			end
			OP_COMMIT: begin
				err = (cmd.amount > free_sp);
				if (!err) begin
					nxt_tail = pos_new;
					nxt_fill = fill_q + cmd.amount;
				end
			end
			OP_CONSUME: begin
				err = (cmd.amount > fill_q);
				if (!err) begin
					nxt_head = pos_new;
					nxt_fill = fill_q - cmd.amount;
				end
			end
			OP_SET: begin
				err   = ({1'b0, cmd.offset} >= fill_q);
				wr_en = !err;
			end
			OP_GET: begin
				err   = ({1'b0, cmd.offset} >= fill_q);
				rd_en = !err;
			end
			OP_FILL: begin
				err   = ({1'b0, cmd.offset} >= free_sp);
				wr_en = !err;
			end
			OP_RD_SEG, OP_WR_SEG: begin
				err = (cmd.op == OP_RD_SEG) ? (cmd.amount > fill_q) : (cmd.amount > free_sp);
				if (!err && (cmd.amount != '0)) begin
					r_start = base;
					if (seg_one) begin
						r_len = cmd.amount;
					end else begin
						r_len  = seg_first;
						r_has2 = 1'b1;
						r_len2 = seg_rest;
					end
				end
			end
			default: begin
				err = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && wr_en) begin
			mem_q[pos_new] <= cmd.data;
		end
		if (cmd_pop && rd_en) begin
			rd_q <= mem_q[pos_new];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CNT_W'(DEPTH);
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else if (cfg_we) begin
			cap_q  <= cfg_cap;
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else if (cmd_pop) begin
			head_q <= nxt_head;
			tail_q <= nxt_tail;
			fill_q <= nxt_fill;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s1 <= 1'b0;
			res_has2_s1  <= 1'b0;
		end else if (cmd_pop) begin
			res_valid_s1 <= 1'b1;
			res_has2_s1  <= r_has2;
		end else if (rsp_acc) begin
			if (res_has2_s1) begin
				res_has2_s1 <= 1'b0;
			end else begin
				res_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			res_status_s1 <= err;
			res_get_s1    <= rd_en;
			res_start_s1  <= r_start;
			res_len_s1    <= r_len;
			res_last_s1   <= !r_has2;
			res_cnt_s1    <= nxt_fill;
			res_len2_s1   <= r_len2;
		end else if (rsp_acc && res_has2_s1) begin
			res_start_s1 <= '0;
			res_len_s1   <= res_len2_s1;
			res_last_s1  <= 1'b1;
		end
	end

	assign rsp.valid          = res_valid_s1;
	assign rsp.status         = res_status_s1;
	assign rsp.read_byte      = res_get_s1 ? rd_q : '0;
	assign rsp.seg_start      = res_start_s1;
	assign rsp.seg_length     = res_len_s1;
	assign rsp.last           = res_last_s1;
	assign rsp.readable_count = res_cnt_s1;

	assign stat.cap  = cap_q;
	assign stat.fill = fill_q;
	assign stat.head = head_q;
	assign stat.tail = tail_q;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the circular byte buffer. A queue of operations, built from
// directed corner cases and then mostly well-formed random traffic, is fed
// into the request channel under random idling. A ring model in the
// testbench gives the expected response items for each operation. A monitor
// checks every response item field by field. The capacity register is
// rewritten between phases, including its extremes. A long response stall
// fills the block up and stalls its input.
// ----------------------------------------------------------------------------
module tb_top;
	import cbb_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned HOLD_CYCLES    = 160;
	localparam int unsigned N_CAPS         = 9;
	localparam int unsigned CAP_LIST [N_CAPS] = '{1, 16, 8191, 0, 7, 300, 5000, 64, 4096};

	typedef struct packed {
		logic              status;
		logic [DATA_W-1:0] read_byte;
		logic [ADDR_W-1:0] seg_start;
		logic [CNT_W-1:0]  seg_length;
		logic              last;
		logic [CNT_W-1:0]  readable_count;
	} rsp_item_t;

	typedef struct {
		cbb_cmd_t    cmd;
		int unsigned n_res;
		rsp_item_t   res0;
		rsp_item_t   res1;
	} op_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cbb_in_if  req ();
	cbb_out_if rsp ();
	cbb_cfg_if cfg ();

	circular_byte_buffer_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	always #10 clk = ~clk;

	// ring model
	int unsigned       ring_cap = DEPTH;
	int unsigned       ring_head = 0;
	int unsigned       ring_tail = 0;
	int unsigned       ring_fill = 0;
	logic [DATA_W-1:0] ring_mem [DEPTH];
	bit                written_map [DEPTH];

	op_item_t    pending_ops [$];
	rsp_item_t   expected_rsp_q [$];
	op_item_t    in_flight;
	int unsigned ops_queued = 0;
	int unsigned ops_accepted = 0;
	int unsigned results_seen = 0;
	int unsigned errors = 0;
	int unsigned cyc = 0;
	int unsigned idle_cycles = 0;
	int unsigned hold_left = 0;
	int unsigned holds_done = 0;
	logic        calm;

	assign calm = (cyc >= 800) && (cyc < 1800);

	function automatic void ring_configure(logic [CNT_W-1:0] v);
		if (v == 0)
			ring_cap = 1;
		else if (v > DEPTH)
			ring_cap = DEPTH;
		else
			ring_cap = 32'(v);
		ring_head = 0;
		ring_tail = 0;
		ring_fill = 0;
	endfunction

	function automatic op_item_t ring_predict(cbb_cmd_t c);
		op_item_t    it;
		int unsigned n;
		int unsigned off;
		int unsigned room;
		int unsigned pos;
		int unsigned first;
		bit          bad;
		bit          listing;
		n = 32'(c.amount);
		off = 32'(c.offset);
		room = ring_cap - ring_fill;
		bad = 1'b0;
		listing = 1'b0;
		pos = 0;
		it.cmd = c;
		it.n_res = 1;
		it.res0 = '0;
		it.res1 = '0;
		case (c.op)
			OP_CLEAR: begin
				ring_head = 0;
				ring_tail = 0;
				ring_fill = 0;
			end
			OP_COMMIT: begin
				if (n > room) begin
					bad = 1'b1;
				end else begin
					ring_tail = (ring_tail + n) % ring_cap;
					ring_fill += n;
				end
			end
			OP_CONSUME: begin
				if (n > ring_fill) begin
					bad = 1'b1;
				end else begin
					ring_head = (ring_head + n) % ring_cap;
					ring_fill -= n;
				end
			end
			OP_SET: begin
				if (off >= ring_fill) begin
					bad = 1'b1;
				end else begin
					pos = (ring_head + off) % ring_cap;
					ring_mem[pos] = c.data;
					written_map[pos] = 1'b1;
				end
			end
			OP_GET: begin
				if (off >= ring_fill)
					bad = 1'b1;
				else
					it.res0.read_byte = ring_mem[(ring_head + off) % ring_cap];
			end
			OP_RD_SEG: begin
				bad = (n > ring_fill);
				listing = 1'b1;
				pos = ring_head;
			end
			OP_WR_SEG: begin
				bad = (n > room);
				listing = 1'b1;
				pos = ring_tail;
			end
			OP_FILL: begin
				if (off >= room) begin
					bad = 1'b1;
				end else begin
					pos = (ring_tail + off) % ring_cap;
					ring_mem[pos] = c.data;
					written_map[pos] = 1'b1;
				end
			end
		endcase
		// a list that runs past the end of the ring wraps to position zero
		if (listing && !bad && n != 0) begin
			first = ring_cap - pos;
			if (first > n)
				first = n;
			it.res0.seg_start = ADDR_W'(pos);
			it.res0.seg_length = CNT_W'(first);
			if (first != n) begin
				it.n_res = 2;
				it.res1.seg_length = CNT_W'(n - first);
			end
		end
		it.res0.status = bad;
		it.res0.last = (it.n_res == 1);
		it.res1.last = 1'b1;
		it.res0.readable_count = CNT_W'(ring_fill);
		it.res1.readable_count = CNT_W'(ring_fill);
		return it;
	endfunction

	task automatic queue_op(cbb_op_t op, int unsigned n, int unsigned off,
		logic [DATA_W-1:0] d);
		cbb_cmd_t c;
		c.op = op;
		c.amount = CNT_W'(n);
		c.offset = ADDR_W'(off);
		c.data = d;
		pending_ops.push_back(ring_predict(c));
		ops_queued++;
	endtask

	task automatic queue_random();
		int unsigned       room;
		int unsigned       n;
		int unsigned       off;
		int unsigned       sel;
		cbb_op_t           op;
		logic [DATA_W-1:0] val;
		room = ring_cap - ring_fill;
		n = $urandom_range(8191);
		off = $urandom_range(4095);
		val = DATA_W'($urandom_range(255));
		sel = $urandom_range(99);
		if (sel < 12) begin
			op = cbb_op_t'($urandom_range(7));
			// half of the noise sits just past the bound
			if ($urandom_range(1) == 1) begin
				n = ((op == OP_CONSUME || op == OP_RD_SEG) ? ring_fill : room) + 1;
				off = (op == OP_FILL) ? room : ring_fill;
				if (off > 4095)
					off = 4095;
			end
		end else if (sel < 14) begin
			op = OP_CLEAR;
		end else if (sel < 28) begin
			op = OP_COMMIT;
			n = $urandom_range(room);
		end else if (sel < 42) begin
			op = OP_CONSUME;
			n = $urandom_range(ring_fill);
		end else if (sel < 52) begin
			if (ring_fill == 0) begin
				op = OP_COMMIT;
				n = $urandom_range(room);
			end else begin
				op = OP_SET;
				off = $urandom_range(ring_fill - 1);
			end
		end else if (sel < 66) begin
			if (ring_fill == 0) begin
				op = OP_COMMIT;
				n = $urandom_range(room);
			end else begin
				op = OP_GET;
				off = $urandom_range(ring_fill - 1);
				for (int i = 0; i < 8 && !written_map[(ring_head + off) % ring_cap]; i++)
					off = $urandom_range(ring_fill - 1);
			end
		end else if (sel < 76) begin
			op = OP_RD_SEG;
			n = $urandom_range(ring_fill);
		end else if (sel < 86) begin
			op = OP_WR_SEG;
			n = $urandom_range(room);
		end else begin
			if (room == 0) begin
				op = OP_CONSUME;
				n = $urandom_range(ring_fill);
			end else begin
				op = OP_FILL;
				off = $urandom_range(room - 1);
			end
		end
		// never read a byte that was never written
		if (op == OP_GET && off < ring_fill && !written_map[(ring_head + off) % ring_cap])
			op = OP_SET;
		queue_op(op, n, off, val);
	endtask

	task automatic drain();
		while (ops_accepted != ops_queued || expected_rsp_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_capacity(logic [CNT_W-1:0] v);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.data <= v;
		do
			@(posedge clk);
		while (!cfg.ready);
		cfg.valid <= 1'b0;
		ring_configure(v);
	endtask

	task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.op <= OP_CLEAR;
			req.amount <= '0;
			req.offset <= '0;
			req.data_in <= '0;
		end else begin
			if (req.valid && req.ready) begin
				expected_rsp_q.push_back(in_flight.res0);
				if (in_flight.n_res == 2)
					expected_rsp_q.push_back(in_flight.res1);
				ops_accepted++;
			end
			if (!req.valid || req.ready) begin
				if (pending_ops.size() != 0 &&
					(calm || hold_left != 0 || $urandom_range(99) >= 22)) begin
					in_flight = pending_ops.pop_front();
					req.valid <= 1'b1;
					req.op <= in_flight.cmd.op;
					req.amount <= in_flight.cmd.amount;
					req.offset <= in_flight.cmd.offset;
					req.data_in <= in_flight.cmd.data;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// response monitor
	always @(posedge clk or negedge arst_n) begin
		rsp_item_t want;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				results_seen++;
				if (expected_rsp_q.size() == 0) begin
					$display("%0t: unexpected item, expected none actual status %0h len %0h",
						$time, rsp.status, rsp.seg_length);
					errors++;
				end else begin
					want = expected_rsp_q.pop_front();
					compare_field("status", 16'(want.status), 16'(rsp.status));
					compare_field("read_byte", 16'(want.read_byte), 16'(rsp.read_byte));
					compare_field("seg_start", 16'(want.seg_start), 16'(rsp.seg_start));
					compare_field("seg_length", 16'(want.seg_length), 16'(rsp.seg_length));
					compare_field("last", 16'(want.last), 16'(rsp.last));
					compare_field("readable_count", 16'(want.readable_count),
						16'(rsp.readable_count));
				end
			end
			if (hold_left != 0) begin
				hold_left--;
			end else if (holds_done < 2 && pending_ops.size() > 60 &&
				results_seen > 250 * (holds_done + 1)) begin
				hold_left = HOLD_CYCLES;
				holds_done++;
			end
			rsp.ready <= (hold_left == 0) && (calm || $urandom_range(99) >= 22);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cyc++;
		if (arst_n && !((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
			(cfg.valid && cfg.ready))) begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end else begin
			idle_cycles = 0;
		end
	end

	initial begin
		cfg.valid <= 1'b0;
		cfg.data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// corner cases at reset capacity
		queue_op(OP_GET, 0, 0, 8'h00);
		queue_op(OP_CONSUME, 1, 0, 8'h00);
		queue_op(OP_RD_SEG, 0, 0, 8'h00);
		queue_op(OP_WR_SEG, 4096, 0, 8'h00);
		queue_op(OP_WR_SEG, 4097, 0, 8'h00);
		queue_op(OP_COMMIT, 8191, 4095, 8'hff);
		queue_op(OP_FILL, 0, 4095, 8'ha5);
		queue_op(OP_FILL, 0, 0, 8'h00);
		queue_op(OP_COMMIT, 4096, 0, 8'h00);
		queue_op(OP_FILL, 0, 0, 8'h11);
		queue_op(OP_SET, 0, 4095, 8'hff);
		queue_op(OP_GET, 0, 4095, 8'h00);
		queue_op(OP_GET, 0, 0, 8'h00);
		queue_op(OP_RD_SEG, 4096, 0, 8'h00);
		queue_op(OP_CONSUME, 4000, 0, 8'h00);
		queue_op(OP_COMMIT, 100, 0, 8'h00);
		queue_op(OP_RD_SEG, 196, 0, 8'h00);
		queue_op(OP_GET, 0, 95, 8'h00);
		queue_op(OP_WR_SEG, 3900, 0, 8'h00);
		queue_op(OP_CONSUME, 196, 0, 8'h00);
		queue_op(OP_WR_SEG, 4096, 0, 8'h00);
		queue_op(OP_COMMIT, 4096, 0, 8'h00);
		queue_op(OP_RD_SEG, 4096, 0, 8'h00);
		queue_op(OP_SET, 0, 4095, 8'h3c);
		queue_op(OP_CLEAR, 8191, 4095, 8'hff);
		repeat (150) queue_random();
		drain();

		for (int i = 0; i < N_CAPS; i++) begin
			write_capacity(CNT_W'(CAP_LIST[i]));
			repeat (120) queue_random();
			drain();
		end

		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
